[sv/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[sv/ffba_pkg.sv]
package ffba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 24;

   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 24;
   localparam int OFS_W      = 25;
   localparam int TYPE_W     = 2;
   localparam int ST_W       = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [OFS_W-1:0] LIMIT_RESET = OFS_W'(16777216);

   localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RESIZE  = 2'd2;

   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
   localparam logic [ST_W-1:0] ST_OOM  = 2'd2;
   localparam logic [ST_W-1:0] ST_BAD  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 1'd1;

   typedef struct packed {
      logic [OFS_W-1:0]  start;
      logic [SIZE_W-1:0] size;
      logic              free;
   } tbl_entry_type;

   typedef struct packed {
      logic             en_all;
      logic             en_free;
      logic [IDX_W-1:0] idx;
      tbl_entry_type    data;
   } tbl_wr_type;

endpackage

[sv/ffba_if.sv]
interface ffba_req_if;
   import ffba_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TYPE_W-1:0]     req_type;
   logic [SIZE_W-1:0]     size_bytes;
   logic [ADDR_W-1:0]     data_address;

   modport source (output valid, output req_type, output size_bytes, output data_address,
                   input ready);
   modport sink (input valid, input req_type, input size_bytes, input data_address,
                 output ready);
endinterface

interface ffba_rsp_if;
   import ffba_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ADDR_W-1:0]     result_address;
   logic [ST_W-1:0]       status;
   logic                  reused;
   logic [SIZE_W-1:0]     copy_bytes;

   modport source (output valid, output result_address, output status, output reused,
                   output copy_bytes, input ready);
   modport sink (input valid, input result_address, input status, input reused,
                 input copy_bytes, output ready);
endinterface

[sv/ffba_table.sv]
module ffba_table (
   input  logic                     clock,
   input  ffba_pkg::tbl_wr_type     wr,
   input  logic [ffba_pkg::IDX_W-1:0] rd_idx,
   output ffba_pkg::tbl_entry_type  rd_data
);
   import ffba_pkg::*;

   logic [OFS_W-1:0]  start_mem [MAX_BLOCKS];
   logic [SIZE_W-1:0] size_mem  [MAX_BLOCKS];
   logic              free_mem  [MAX_BLOCKS];
   tbl_entry_type     rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en_all) begin
         start_mem[wr.idx] <= wr.data.start;
         size_mem[wr.idx]  <= wr.data.size;
      end
      if (wr.en_all || wr.en_free) begin
         free_mem[wr.idx] <= wr.data.free;
      end
      rd_data_ff.start <= start_mem[rd_idx];
      rd_data_ff.size  <= size_mem[rd_idx];
      rd_data_ff.free  <= free_mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/first_fit_block_allocator.sv]
// First-fit heap block allocator. The block table sits in a memory with one write port
// and one registered read port, and is scanned one entry per cycle in address order:
// allocate by first fit, or release and resize looking up their address. An allocation
// that finds no fit appends a new block at the heap top; a resize that has to move scans
// twice. req_if.ready is high only between requests; a finished item waits in the output
// register and the next request is taken meanwhile. The table needs no clearing after
// reset: only entries below the block count are ever read.
`include "assert_macros.svh"

module first_fit_block_allocator (
   input  logic                              clock,
   input  logic                              reset,
   ffba_req_if.sink                          req_if,
   ffba_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [ffba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffba_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ffba_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_APPEND   = 3'd2;
   localparam logic [2:0] S_FREE_OLD = 3'd3;
   localparam logic [2:0] S_REPLY    = 3'd4;

   localparam logic MODE_FIND  = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   localparam logic [ADDR_W-1:0] HDR_ADDR = ADDR_W'(HEADER_BYTES);
   localparam logic [OFS_W:0]    HDR_NEED = (OFS_W + 1)'(HEADER_BYTES);
   localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_BLOCKS);

   logic [2:0]        state_ff, state_in;
   logic              mode_ff, mode_in;
   logic              moving_ff, moving_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [OFS_W-1:0]  used_ff, used_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [OFS_W-1:0]  limit_ff, limit_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [TYPE_W-1:0] type_ff, type_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] target_ff, target_in;
   logic [IDX_W-1:0]  old_idx_ff, old_idx_in;
   logic [SIZE_W-1:0] old_size_ff, old_size_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [ST_W-1:0]   res_status_ff, res_status_in;
   logic              res_reused_ff, res_reused_in;
   logic [SIZE_W-1:0] res_copy_ff, res_copy_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [ST_W-1:0]   out_status_ff, out_status_in;
   logic              out_reused_ff, out_reused_in;
   logic [SIZE_W-1:0] out_copy_ff, out_copy_in;

   tbl_wr_type        tbl_wr;
   tbl_entry_type     rd_data;
   logic              hit;
   logic [OFS_W:0]    need;
   logic              reply_load;
   logic              out_fail;

   ffba_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_idx  (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // shared compare: address match or first fit, one entry a cycle
   always_comb begin
      if (mode_ff == MODE_FIND) begin
         hit = rd_vld_ff && (ADDR_W'(rd_data.start) == target_ff);
      end else begin
         hit = rd_vld_ff && rd_data.free && (rd_data.size >= size_ff);
      end
   end

   assign need = {1'b0, used_ff} + (OFS_W + 1)'(size_ff) + HDR_NEED;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      moving_in     = moving_ff;
      idx_in        = idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = idx_ff[IDX_W-1:0];
      cnt_in        = cnt_ff;
      used_in       = used_ff;
      base_in       = base_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      type_in       = type_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      target_in     = target_ff;
      old_idx_in    = old_idx_ff;
      old_size_in   = old_size_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      res_reused_in = res_reused_ff;
      res_copy_in   = res_copy_ff;
      out_addr_in   = out_addr_ff;
      out_status_in = out_status_ff;
      out_reused_in = out_reused_ff;
      out_copy_in   = out_copy_ff;
      tbl_wr        = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_HEAP_BASE:  base_in  = csr_wdata;
            CSR_HEAP_LIMIT: limit_in = csr_wdata[OFS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               type_in       = req_if.req_type;
               size_in       = req_if.size_bytes;
               addr_in       = req_if.data_address;
               target_in     = req_if.data_address - base_ff - HDR_ADDR;
               res_addr_in   = '0;
               res_status_in = ST_OK;
               res_reused_in = 1'b0;
               res_copy_in   = '0;
               idx_in        = '0;
               moving_in     = 1'b0;
               case (req_if.req_type)
                  REQ_ALLOC, REQ_RESIZE: begin
                     if (req_if.req_type == REQ_RESIZE && req_if.data_address != '0) begin
                        mode_in  = MODE_FIND;
                        state_in = S_SCAN;
                     end else if (req_if.size_bytes == '0) begin
                        res_status_in = ST_ZERO;
                        state_in      = S_REPLY;
                     end else begin
                        mode_in  = MODE_ALLOC;
                        state_in = S_SCAN;
                     end
                  end
                  REQ_RELEASE: begin
                     if (req_if.data_address == '0) begin
                        state_in = S_REPLY;
                     end else begin
                        mode_in  = MODE_FIND;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     res_status_in = ST_BAD;
                     state_in      = S_REPLY;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (idx_ff < cnt_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[IDX_W-1:0];
               idx_in    = idx_ff + 1'b1;
            end
            if (hit) begin
               rd_vld_in = 1'b0;
               if (mode_ff == MODE_FIND) begin
                  if (rd_data.free) begin
                     res_status_in = ST_BAD;
                     state_in      = S_REPLY;
                  end else if (type_ff == REQ_RELEASE) begin
                     tbl_wr.en_free   = 1'b1;
                     tbl_wr.idx       = rd_idx_ff;
                     tbl_wr.data.free = 1'b1;
                     state_in         = S_REPLY;
                  end else if (rd_data.size >= size_ff) begin
                     res_addr_in = addr_ff;
                     state_in    = S_REPLY;
                  end else begin
                     // block too small: look for a new home
                     mode_in     = MODE_ALLOC;
                     moving_in   = 1'b1;
                     old_idx_in  = rd_idx_ff;
                     old_size_in = rd_data.size;
                     idx_in      = '0;
                  end
               end else begin
                  tbl_wr.en_free   = 1'b1;
                  tbl_wr.idx       = rd_idx_ff;
                  tbl_wr.data.free = 1'b0;
                  res_addr_in      = base_ff + ADDR_W'(rd_data.start) + HDR_ADDR;
                  res_reused_in    = 1'b1;
                  state_in         = moving_ff ? S_FREE_OLD : S_REPLY;
               end
            end else if (!rd_vld_ff && idx_ff >= cnt_ff) begin
               if (mode_ff == MODE_FIND) begin
                  res_status_in = ST_BAD;
                  state_in      = S_REPLY;
               end else begin
                  state_in = S_APPEND;
               end
            end
         end

         S_APPEND: begin
            if (cnt_ff == CNT_FULL || need > {1'b0, limit_ff}) begin
               res_status_in = ST_OOM;
               state_in      = S_REPLY;
            end else begin
               tbl_wr.en_all     = 1'b1;
               tbl_wr.idx        = cnt_ff[IDX_W-1:0];
               tbl_wr.data.start = used_ff;
               tbl_wr.data.size  = size_ff;
               tbl_wr.data.free  = 1'b0;
               cnt_in            = cnt_ff + 1'b1;
               used_in           = need[OFS_W-1:0];
               res_addr_in       = base_ff + ADDR_W'(used_ff) + HDR_ADDR;
               state_in          = moving_ff ? S_FREE_OLD : S_REPLY;
            end
         end

         S_FREE_OLD: begin
            tbl_wr.en_free   = 1'b1;
            tbl_wr.idx       = old_idx_ff;
            tbl_wr.data.free = 1'b1;
            res_copy_in      = old_size_ff;
            state_in         = S_REPLY;
         end

         S_REPLY: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               out_addr_in   = res_addr_ff;
               out_status_in = res_status_ff;
               out_reused_in = res_reused_ff;
               out_copy_in   = res_copy_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_FIND;
         moving_ff    <= 1'b0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         cnt_ff       <= '0;
         used_ff      <= '0;
         base_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         moving_ff    <= moving_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      type_ff       <= type_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      target_ff     <= target_in;
      old_idx_ff    <= old_idx_in;
      old_size_ff   <= old_size_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      res_reused_ff <= res_reused_in;
      res_copy_ff   <= res_copy_in;
      out_addr_ff   <= out_addr_in;
      out_status_ff <= out_status_in;
      out_reused_ff <= out_reused_in;
      out_copy_ff   <= out_copy_in;
   end

   assign req_if.ready          = (state_ff == S_IDLE) && !reset;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.result_address = out_addr_ff;
   assign rsp_if.status         = out_status_ff;
   assign rsp_if.reused         = out_reused_ff;
   assign rsp_if.copy_bytes     = out_copy_ff;

   assign reply_load = (state_ff == S_REPLY) && (!rsp_valid_ff || rsp_if.ready);
   assign out_fail   = rsp_valid_ff && (out_status_ff != ST_OK);

   `ASSERT_IMPLIES(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_FULL)
   `ASSERT_IMPLIES(a_read_live, clock, reset, rd_vld_ff, CNT_W'(rd_idx_ff) < cnt_ff)
   `ASSERT_NEXT(a_cnt_only_append, clock, reset, state_ff != S_APPEND, cnt_ff == $past(cnt_ff))
   `ASSERT_NEXT(a_reply_out, clock, reset, reply_load, rsp_valid_ff && state_ff == S_IDLE)
   `ASSERT_IMPLIES(a_fail_no_addr, clock, reset, out_fail, out_addr_ff == '0 && out_copy_ff == '0)

endmodule

[tb/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ffba_pkg::*;

   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int HOLD_CYCLES  = 500;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS  = 50;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [ST_W-1:0]   status;
      logic              reused;
      logic [SIZE_W-1:0] copy_bytes;
   } heap_reply_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ffba_req_if req_ch ();
   ffba_rsp_if rsp_ch ();

   first_fit_block_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // heap bookkeeping mirrored from the block
   logic [OFS_W-1:0]  blk_start [MAX_BLOCKS];
   logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
   bit                blk_free  [MAX_BLOCKS];
   int                blk_count;
   logic [OFS_W-1:0]  heap_top;
   logic [ADDR_W-1:0] cur_base;
   logic [OFS_W-1:0]  cur_limit;

   heap_reply_type replies_due [$];

   int send_idle_pct;
   int rcv_idle_pct;
   int hold_requests;
   int failures;
   int n_requests;
   int n_checked;
   int n_reused;
   int n_oom;
   int n_bad;

   function automatic logic [ADDR_W-1:0] payload_of(int i);
      return cur_base + ADDR_W'(blk_start[i]) + ADDR_W'(HEADER_BYTES);
   endfunction

   function automatic int lookup(logic [ADDR_W-1:0] ad);
      for (int i = 0; i < blk_count; i++)
         if (payload_of(i) == ad)
            return i;
      return MAX_BLOCKS;
   endfunction

   // first fit over the table, else append at the heap top
   function automatic logic [ST_W-1:0] grab_block(input logic [SIZE_W-1:0] sz,
                                                 output logic [ADDR_W-1:0] ad,
                                                 output logic was_reused);
      longint need;
      ad = '0;
      was_reused = 1'b0;
      if (sz == 0)
         return ST_ZERO;
      for (int i = 0; i < blk_count; i++) begin
         if (blk_free[i] && blk_size[i] >= sz) begin
            blk_free[i] = 1'b0;
            ad = payload_of(i);
            was_reused = 1'b1;
            return ST_OK;
         end
      end
      need = longint'(heap_top) + longint'(sz) + HEADER_BYTES;
      if (blk_count >= MAX_BLOCKS || need > longint'(cur_limit))
         return ST_OOM;
      blk_start[blk_count] = heap_top;
      blk_size[blk_count] = sz;
      blk_free[blk_count] = 1'b0;
      ad = payload_of(blk_count);
      blk_count++;
      heap_top = OFS_W'(need);
      return ST_OK;
   endfunction

   function automatic heap_reply_type compute_reply(logic [TYPE_W-1:0] kind,
                                                    logic [SIZE_W-1:0] sz,
                                                    logic [ADDR_W-1:0] ad);
      heap_reply_type r;
      int i;
      r = '0;
      case (kind)
         REQ_ALLOC: begin
            r.status = grab_block(sz, r.address, r.reused);
         end
         REQ_RELEASE: begin
            if (ad != 0) begin
               i = lookup(ad);
               if (i >= MAX_BLOCKS || blk_free[i])
                  r.status = ST_BAD;
               else
                  blk_free[i] = 1'b1;
            end
         end
         REQ_RESIZE: begin
            if (ad == 0) begin
               r.status = grab_block(sz, r.address, r.reused);
            end else begin
               i = lookup(ad);
               if (i >= MAX_BLOCKS || blk_free[i]) begin
                  r.status = ST_BAD;
               end else if (blk_size[i] >= sz) begin
                  r.address = ad;
               end else begin
                  r.status = grab_block(sz, r.address, r.reused);
                  if (r.status == ST_OK) begin
                     r.copy_bytes = blk_size[i];
                     blk_free[i] = 1'b1;
                  end
               end
            end
         end
         default: begin
            r.status = ST_BAD;
         end
      endcase
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70)
         return SIZE_W'($urandom_range(64, 1));
      if (roll < 90)
         return SIZE_W'($urandom_range(4096, 65));
      if (roll < 95)
         return '0;
      return SIZE_W'($urandom_range(24'hFF_FFFF, 24'h80_0000));
   endfunction

   // mostly a live block, sometimes a free one or a stray address
   function automatic logic [ADDR_W-1:0] pick_address();
      int i;
      if (blk_count == 0 || $urandom_range(19) == 0)
         return $urandom;
      i = $urandom_range(blk_count - 1);
      if ($urandom_range(4) != 0)
         for (int n = 0; n < blk_count && blk_free[i]; n++)
            i = (i + 1) % blk_count;
      return payload_of(i);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endfunction

   task automatic issue_request(input logic [TYPE_W-1:0] kind, input logic [SIZE_W-1:0] sz,
                                input logic [ADDR_W-1:0] ad);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.size_bytes <= sz;
      req_ch.data_address <= ad;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      replies_due.push_back(compute_reply(kind, sz, ad));
      n_requests++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HEAP_BASE)
         cur_base = val;
      else
         cur_limit = OFS_W'(val);
      @(negedge clock);
   endtask

   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      while (replies_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_items(int count);
      logic [TYPE_W-1:0] kind;
      logic [SIZE_W-1:0] sz;
      logic [ADDR_W-1:0] ad;
      int roll;
      repeat (count) begin
         roll = $urandom_range(99);
         sz = pick_size();
         ad = '0;
         if (roll < 40) begin
            kind = REQ_ALLOC;
         end else if (roll < 70) begin
            kind = REQ_RELEASE;
            ad = pick_address();
         end else if (roll < 90) begin
            kind = REQ_RESIZE;
            ad = ($urandom_range(7) == 0) ? '0 : pick_address();
         end else begin
            kind = TYPE_W'($urandom_range(3));
            sz = SIZE_W'($urandom);
            ad = $urandom;
         end
         issue_request(kind, sz, ad);
      end
   endtask

   task automatic test_directed();
      issue_request(REQ_ALLOC, '0, '0);
      issue_request(REQ_ALLOC, 24'd100, '0);
      issue_request(REQ_ALLOC, 24'hFF_FFFF, '0);
      issue_request(REQ_ALLOC, 24'd1, '0);
      issue_request(REQ_RELEASE, 24'd7, '0);
      issue_request(REQ_RELEASE, '0, 32'hFFFF_FFFF);
      issue_request(REQ_RELEASE, '0, payload_of(0));
      issue_request(REQ_RELEASE, '0, payload_of(0));
      issue_request(REQ_RESIZE, 24'd10, payload_of(0));
      issue_request(REQ_ALLOC, 24'd50, '0);
      issue_request(REQ_RESIZE, '0, payload_of(0));
      issue_request(REQ_RESIZE, 24'd100, payload_of(0));
      issue_request(REQ_RESIZE, 24'd200, payload_of(1));
      issue_request(REQ_RESIZE, 24'd8, '0);
      issue_request(REQ_RESIZE, 24'hFF_FFFF, payload_of(2));
      issue_request(REQ_UNUSED, 24'd5, payload_of(2));
      issue_request(REQ_ALLOC, 24'd1, '0);
      issue_request(REQ_RELEASE, '0, payload_of(2) + 1);
      issue_request(REQ_RESIZE, '0, '0);
   endtask

   task automatic test_base_and_limit();
      drain_replies();
      write_reg(CSR_HEAP_BASE, 32'hFFFF_FFFF);
      write_reg(CSR_HEAP_LIMIT, '0);
      issue_request(REQ_ALLOC, 24'd500, '0);
      issue_request(REQ_RELEASE, '0, payload_of(0));
      issue_request(REQ_ALLOC, 24'd30, '0);
      issue_request(REQ_RESIZE, 24'd1000, payload_of(3));
      issue_request(REQ_RELEASE, '0, 32'd24);
      drain_replies();
      write_reg(CSR_HEAP_BASE, '0);
      write_reg(CSR_HEAP_LIMIT, CSR_DATA_W'(heap_top + HEADER_BYTES + 16));
      issue_request(REQ_ALLOC, 24'd16, '0);
      issue_request(REQ_ALLOC, 24'd17, '0);
      drain_replies();
      write_reg(CSR_HEAP_LIMIT, CSR_DATA_W'(LIMIT_RESET));
      issue_request(REQ_ALLOC, 24'hFF_FFFF, '0);
   endtask

   task automatic test_slow_receiver();
      drain_replies();
      send_idle_pct = 12;
      rcv_idle_pct = 69;
      write_reg(CSR_HEAP_BASE, $urandom);
      random_items(125);
   endtask

   task automatic test_tight_limit();
      int lim;
      drain_replies();
      send_idle_pct = 69;
      rcv_idle_pct = 12;
      lim = int'(heap_top) + 2000;
      if (lim > int'(LIMIT_RESET))
         lim = int'(LIMIT_RESET);
      write_reg(CSR_HEAP_BASE, $urandom);
      write_reg(CSR_HEAP_LIMIT, CSR_DATA_W'(lim));
      random_items(125);
   endtask

   task automatic test_full_rate();
      drain_replies();
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      write_reg(CSR_HEAP_BASE, '0);
      write_reg(CSR_HEAP_LIMIT, CSR_DATA_W'(LIMIT_RESET));
      random_items(125);
   endtask

   task automatic test_table_full();
      logic [SIZE_W-1:0] widest;
      for (int n = 0; n < 3 * MAX_BLOCKS && blk_count < MAX_BLOCKS; n++)
         issue_request(REQ_ALLOC, SIZE_W'($urandom_range(64, 1)), '0);
      widest = '0;
      for (int i = 0; i < blk_count; i++)
         if (blk_free[i] && blk_size[i] > widest)
            widest = blk_size[i];
      if (widest != 24'hFF_FFFF)
         issue_request(REQ_ALLOC, SIZE_W'(widest + 1), '0);
      issue_request(REQ_RELEASE, '0, payload_of(blk_count - 1));
      issue_request(REQ_ALLOC, 24'd1, '0);
      issue_request(REQ_RESIZE, 24'd5000, payload_of(0));
   endtask

   task automatic test_backpressure();
      drain_replies();
      @(posedge clock);
      hold_requests++;
      @(negedge clock);
      random_items(16);
      drain_replies();
      random_items(8);
   endtask

   // result side: random stalls plus an occasional long hold-off
   initial begin
      int stall_left;
      int holds_served;
      stall_left = 0;
      holds_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      heap_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_checked++;
         if (rsp_ch.reused === 1'b1)
            n_reused++;
         if (rsp_ch.status === ST_OOM)
            n_oom++;
         if (rsp_ch.status === ST_BAD)
            n_bad++;
         if (replies_due.size() == 0) begin
            failures++;
            $error("reply with nothing outstanding: address 0x%0h status %0d",
                   rsp_ch.result_address, rsp_ch.status);
         end else begin
            want = replies_due.pop_front();
            check_field("result_address", want.address, rsp_ch.result_address);
            check_field("status", 32'(want.status), 32'(rsp_ch.status));
            check_field("reused", 32'(want.reused), 32'(rsp_ch.reused));
            check_field("copy_bytes", 32'(want.copy_bytes), 32'(rsp_ch.copy_bytes));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_top failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_HEAP_BASE;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_ALLOC;
      req_ch.size_bytes = '0;
      req_ch.data_address = '0;
      blk_count = 0;
      heap_top = '0;
      cur_base = '0;
      cur_limit = LIMIT_RESET;
      send_idle_pct = 12;
      rcv_idle_pct = 69;
      hold_requests = 0;
      failures = 0;
      n_requests = 0;
      n_checked = 0;
      n_reused = 0;
      n_oom = 0;
      n_bad = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_base_and_limit();
      test_slow_receiver();
      test_tight_limit();
      test_full_rate();
      test_table_full();
      test_backpressure();
      drain_replies();

      $display("%0d requests sent, %0d replies checked: %0d reused, %0d out of memory, %0d bad",
               n_requests, n_checked, n_reused, n_oom, n_bad);
      $display("block table reached %0d entries, heap top %0d bytes", blk_count, heap_top);
      if (failures == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/ffba_pkg.sv
sv/ffba_if.sv
sv/ffba_table.sv
sv/first_fit_block_allocator.sv
tb/tb_top.sv
